// ===== hw/rtl/b64lw_pkg.sv =====
// Package for the line-wrapped base64 encoder: job type, character codes
// and the sextet-to-character mapping. No dependencies.
`default_nettype none

package b64lw_pkg;

	localparam logic [7:0] LINE_FEED     = 8'h0A;
	localparam logic [7:0] PAD_CHAR      = 8'h3D;
	localparam logic [7:0] LINE_WIDTH_RST = 8'd72;

	// Queue between the front and the back.
	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);

	// Index of the line feed slot in a job.
	localparam logic [2:0] LF_SLOT   = 3'd4;
	localparam logic [2:0] LAST_CHAR = 3'd3;

	// One encoded group: four characters, an optional line feed, end mark.
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic            lf;
		logic            fin;
	} job_t;

	// Push request from the front into the queue.
	typedef struct packed {
		logic valid;
		job_t job;
	} push_t;

	// Maps a sextet onto the standard base64 alphabet.
	function automatic logic [7:0] sym(input logic [5:0] v);
		logic [7:0] r;
		if (v < 6'd26) begin
			r = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			r = 8'h61 + {2'b00, v} - 8'd26;
		end else if (v < 6'd62) begin
			r = 8'h30 + {2'b00, v} - 8'd52;
		end else if (v == 6'd62) begin
			r = 8'h2B;
		end else begin
			r = 8'h2F;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/base64_line_wrapped_encoder_top.sv =====
// Top level of the line-wrapped base64 encoder: line width register,
// front, job queue and back. Uses b64lw_pkg and the b64lw_* modules.
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  data_byte, final_byte
// out       output     out_valid / out_stall out_char, run_end, message_end
// cfg       input      cfg_valid / cfg_ready cfg_data (line width)
//
// The back emits one character per cycle; a stalled output holds its
// request and the queue lets the front keep going. Three bytes give four
// characters, five with a line feed; a tail group gives five. The front
// accepts a byte per cycle while the two-entry job queue has room. Reset
// clears the group, line position and queue and loads a line width of 72.
`default_nettype none

module base64_line_wrapped_encoder_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       final_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_char,
	output logic            run_end,
	output logic            message_end,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data
);
	import b64lw_pkg::*;

	logic [7:0] line_width_q;
	logic       accept;
	logic       full;
	logic       empty;
	logic       pop;
	push_t      push;
	job_t       head;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;
	assign accept    = in_valid & !full;

	// Line width register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			line_width_q <= cfg_data;
		end
	end

	b64lw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.line_width (line_width_q),
		.push       (push)
	);

	b64lw_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.full   (full),
		.empty  (empty)
	);

	b64lw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.run_end     (run_end),
		.message_end (message_end)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/b64lw_front.sv =====
// Front of the encoder: holds the group in progress, tracks the line
// position and builds one job per complete or final group. Uses b64lw_pkg.
`default_nettype none

module b64lw_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic [7:0]      data_byte,
	input  wire logic            final_byte,
	input  wire logic [7:0]      line_width,
	output b64lw_pkg::push_t     push
);
	import b64lw_pkg::*;

	logic [1:0][7:0] held_q;
	logic [1:0]      fill_q;
	logic [7:0]      line_count_q;

	logic       fill2;
	logic       fill0;
	logic [7:0] a0;
	logic [8:0] total;
	logic       wrap;
	job_t       job;

	assign fill2 = fill_q[1];
	assign fill0 = (fill_q == 2'd0);
	assign a0    = fill0 ? data_byte : held_q[0];
	assign total = {1'b0, line_count_q} + 9'd4;
	assign wrap  = (total >= {1'b0, line_width});

	// Build the job for a complete group or a partial tail.
	always_comb begin
		job.fin = final_byte;
		if (fill2) begin
			job.chars[0] = sym(held_q[0][7:2]);
			job.chars[1] = sym({held_q[0][1:0], held_q[1][7:4]});
			job.chars[2] = sym({held_q[1][3:0], data_byte[7:6]});
			job.chars[3] = sym(data_byte[5:0]);
			job.lf       = wrap | final_byte;
		end else begin
			job.chars[0] = sym(a0[7:2]);
			if (fill0) begin
				job.chars[1] = sym({a0[1:0], 4'b0000});
				job.chars[2] = PAD_CHAR;
			end else begin
				job.chars[1] = sym({a0[1:0], data_byte[7:4]});
				job.chars[2] = sym({data_byte[3:0], 2'b00});
			end
			job.chars[3] = PAD_CHAR;
			job.lf       = 1'b1;
		end
	end

	assign push.valid = accept & (fill2 | final_byte);
	assign push.job   = job;

	// Group and line state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			fill_q       <= 2'd0;
			line_count_q <= 8'd0;
		end else if (accept) begin
			if (final_byte) begin
				held_q       <= '0;
				fill_q       <= 2'd0;
				line_count_q <= 8'd0;
			end else if (fill2) begin
				fill_q       <= 2'd0;
				line_count_q <= wrap ? 8'd0 : total[7:0];
			end else begin
				held_q[fill_q[0]] <= data_byte;
				fill_q            <= fill_q + 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/b64lw_queue.sv =====
// Short job queue between the front and the back of the encoder.
// Uses b64lw_pkg for the job type and depth.
`default_nettype none

module b64lw_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire b64lw_pkg::push_t push,
	input  wire logic            pop,
	output b64lw_pkg::job_t      head,
	output logic                 full,
	output logic                 empty
);
	import b64lw_pkg::*;

	job_t             entry_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     count_q;

	assign full  = (count_q == (QAW+1)'(QDEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.job;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push.valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push.valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/b64lw_back.sv =====
// Back of the encoder: walks the head job one character per cycle into
// the output register unless stalled. Uses b64lw_pkg's job type, codes.
`default_nettype none

module b64lw_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire b64lw_pkg::job_t head,
	input  wire logic            empty,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [7:0]           out_char,
	output logic                 run_end,
	output logic                 message_end
);
	import b64lw_pkg::*;

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] char_q;
	logic       run_end_q;
	logic       msg_end_q;

	logic       load;
	logic       last;
	logic [7:0] next_char;

	assign load = !empty && (!out_valid_q || !out_stall);
	assign last = (idx_q == LF_SLOT) || (idx_q == LAST_CHAR && !head.lf);
	assign pop  = load && last;

	// Pick the character of the current slot.
	always_comb begin
		if (idx_q == LF_SLOT) begin
			next_char = LINE_FEED;
		end else begin
			next_char = head.chars[idx_q[1:0]];
		end
	end

	// Slot counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= last ? 3'd0 : idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			char_q    <= next_char;
			run_end_q <= last;
			msg_end_q <= last & head.fin;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_char    = char_q;
	assign run_end     = run_end_q;
	assign message_end = msg_end_q;

endmodule

`default_nettype wire
